>>> hdl/scp_pkg.sv
package scp_pkg;

    // fractional bits of the world coordinate unit
    localparam int COORD_FRAC_BITS = 4;
    localparam int CAM_FRAC        = 8;
    localparam int ROT_SHIFT       = 20;
    localparam int ROT_PRE         = 14;
    localparam int T_FRAC          = 28;

    // width of a rotated camera coordinate
    localparam int CW = 34;
    localparam int NEAR_Q_INT = ((1 << (COORD_FRAC_BITS + CAM_FRAC)) + 2) / 5;
    localparam logic signed [CW-1:0] NEAR_Q = CW'(NEAR_Q_INT);

    // pixel quotient bits before saturation
    localparam int QB = 17;

    localparam int ROT_LAT  = 4;
    localparam int CLIP_LAT = T_FRAC + 8;
    localparam int PIX_LAT  = QB + 5;
    localparam int PIPE_LAT = ROT_LAT + CLIP_LAT + PIX_LAT;

    typedef enum logic [2:0] {
        CFG_CAM_X     = 3'd0,
        CFG_CAM_Y     = 3'd1,
        CFG_CAM_Z     = 3'd2,
        CFG_HEADING   = 3'd3,
        CFG_TILT      = 3'd4,
        CFG_FOCAL     = 3'd5,
        CFG_PRINCIPAL = 3'd6
    } t_cfg_idx;

    typedef struct packed {
        logic signed [19:0] start_x;
        logic signed [19:0] start_y;
        logic signed [19:0] start_z;
        logic signed [19:0] end_x;
        logic signed [19:0] end_y;
        logic signed [19:0] end_z;
    } t_in_word;

    typedef struct packed {
        logic               visible;
        logic signed [15:0] start_u;
        logic signed [15:0] start_v;
        logic signed [15:0] end_u;
        logic signed [15:0] end_v;
    } t_out_word;

    typedef struct packed {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [CW-1:0] z;
    } t_cam_pt;

    typedef struct packed {
        logic signed [15:0] cph;
        logic signed [15:0] sph;
        logic signed [15:0] ct;
        logic signed [15:0] st;
    } t_rot_cfg;

    // arithmetic shift right by k, rounded to nearest, ties to even
    function automatic logic signed [63:0] rne_shift(input logic signed [63:0] v, input int k);
        logic signed [63:0] q;
        logic [63:0] mask;
        logic [63:0] r;
        logic [63:0] half;
        q    = v >>> k;
        mask = (64'd1 << k) - 64'd1;
        r    = v & mask;
        half = 64'd1 << (k - 1);
        if (r > half || (r == half && q[0])) begin
            q = q + 64'sd1;
        end
        return q;
    endfunction

endpackage

>>> hdl/scp_rotate.sv
module scp_rotate (
    input  logic               i_clk,
    input  logic               i_en,
    input  scp_pkg::t_rot_cfg  i_rot,
    input  logic signed [19:0] i_cam_x,
    input  logic signed [19:0] i_cam_y,
    input  logic signed [19:0] i_cam_z,
    input  logic signed [19:0] i_x,
    input  logic signed [19:0] i_y,
    input  logic signed [19:0] i_z,
    output scp_pkg::t_cam_pt   o_pt
);
    import scp_pkg::*;

    logic signed [20:0] r_dx, r_dy, r_dz;
    logic signed [31:0] r_a, r_b, r_c, r_d;
    logic signed [15:0] r_sph, r_cph, r_ct, r_st;
    logic signed [36:0] r_px1, r_px2, r_py3, r_pz3;
    logic signed [52:0] r_py1, r_py2, r_pz1, r_pz2;
    logic signed [37:0] r_sx;
    logic signed [54:0] r_sy, r_sz;
    t_cam_pt            r_pt;
    logic signed [63:0] n_rx, n_ry, n_rz;

    always_comb begin
        n_rx = rne_shift(64'(r_sx), ROT_SHIFT - ROT_PRE);
        n_ry = rne_shift(64'(r_sy), ROT_SHIFT);
        n_rz = rne_shift(64'(r_sz), ROT_SHIFT);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            // translate, and fold heading into tilt
            r_dx  <= 21'(i_x) - 21'(i_cam_x);
            r_dy  <= 21'(i_y) - 21'(i_cam_y);
            r_dz  <= 21'(i_z) - 21'(i_cam_z);
            r_a   <= 32'(i_rot.cph) * 32'(i_rot.st);
            r_b   <= 32'(i_rot.sph) * 32'(i_rot.st);
            r_c   <= 32'(i_rot.cph) * 32'(i_rot.ct);
            r_d   <= 32'(i_rot.sph) * 32'(i_rot.ct);
            r_sph <= i_rot.sph;
            r_cph <= i_rot.cph;
            r_ct  <= i_rot.ct;
            r_st  <= i_rot.st;
            // products
            r_px1 <= 37'(r_sph) * 37'(r_dx);
            r_px2 <= 37'(r_cph) * 37'(r_dy);
            r_py1 <= 53'(r_a) * 53'(r_dx);
            r_py2 <= 53'(r_b) * 53'(r_dy);
            r_py3 <= 37'(r_ct) * 37'(r_dz);
            r_pz1 <= 53'(r_c) * 53'(r_dx);
            r_pz2 <= 53'(r_d) * 53'(r_dy);
            r_pz3 <= 37'(r_st) * 37'(r_dz);
            // sums
            r_sx  <= 38'(r_px1) - 38'(r_px2);
            r_sy  <= 55'(r_py1) + 55'(r_py2) - (55'(r_py3) <<< ROT_PRE);
            r_sz  <= 55'(r_pz1) + 55'(r_pz2) + (55'(r_pz3) <<< ROT_PRE);
            // round to camera scale
            r_pt.x <= CW'(n_rx);
            r_pt.y <= CW'(n_ry);
            r_pt.z <= CW'(n_rz);
        end
    end

    assign o_pt = r_pt;

endmodule

>>> hdl/scp_clip.sv
module scp_clip (
    input  logic             i_clk,
    input  logic             i_en,
    input  scp_pkg::t_cam_pt i_p0,
    input  scp_pkg::t_cam_pt i_p1,
    output logic             o_vis,
    output scp_pkg::t_cam_pt o_q0,
    output scp_pkg::t_cam_pt o_q1
);
    import scp_pkg::*;

    localparam int NW = CW + 1;
    localparam int CRY_N = CLIP_LAT - 1;

    typedef struct packed {
        logic    vis;
        t_cam_pt p0;
        t_cam_pt p1;
    } t_cry;

    t_cry               r_cry [0:CRY_N-1];
    logic signed [NW-1:0] r_num, r_den;
    logic [NW-1:0]      r_nn, r_dd;
    logic [NW-1:0]      r_rem [0:T_FRAC];
    logic [T_FRAC:0]    r_q   [0:T_FRAC];
    logic [NW-1:0]      r_dv  [0:T_FRAC];
    logic [T_FRAC:0]    r_s;
    logic [46:0]        r_mlo_x, r_mlo_y;
    logic signed [46:0] r_mhi_x, r_mhi_y;
    logic signed [63:0] r_prod_x, r_prod_y;
    logic signed [CW-1:0] r_crx, r_cry_y;
    logic               r_vis;
    t_cam_pt            r_q0, r_q1;

    logic signed [NW-1:0] n_tn, n_td;
    logic [NW-1:0]      n_nn, n_dd;
    logic               n_ge0;
    logic [NW:0]        n_rem2 [1:T_FRAC];
    logic               n_ge   [1:T_FRAC];
    logic [NW-1:0]      n_rem  [1:T_FRAC];
    logic               n_up;
    logic signed [NW-1:0] n_dfx, n_dfy;
    logic signed [63:0] n_cx, n_cy;

    // sign fix of the crossing fraction; equal depths give zero
    always_comb begin
        n_tn = r_num;
        n_td = r_den;
        if (r_den == '0) begin
            n_tn = '0;
            n_td = NW'(1);
        end else if (r_den[NW-1]) begin
            n_tn = -r_num;
            n_td = -r_den;
        end
        n_nn = n_tn[NW-1] ? '0 : $unsigned(n_tn);
        n_dd = $unsigned(n_td);
    end

    assign n_ge0 = r_nn >= r_dd;

    always_comb begin
        for (int j = 1; j <= T_FRAC; j++) begin
            n_rem2[j] = {r_rem[j-1], 1'b0};
            n_ge[j]   = n_rem2[j] >= {1'b0, r_dv[j-1]};
            n_rem[j]  = n_ge[j] ? NW'(n_rem2[j] - {1'b0, r_dv[j-1]}) : NW'(n_rem2[j]);
        end
    end

    assign n_up = ({r_rem[T_FRAC], 1'b0} > {1'b0, r_dv[T_FRAC]})
               || (({r_rem[T_FRAC], 1'b0} == {1'b0, r_dv[T_FRAC]}) && r_q[T_FRAC][0]);

    assign n_dfx = NW'(r_cry[CRY_N-4].p1.x) - NW'(r_cry[CRY_N-4].p0.x);
    assign n_dfy = NW'(r_cry[CRY_N-4].p1.y) - NW'(r_cry[CRY_N-4].p0.y);

    assign n_cx = 64'(r_cry[CRY_N-2].p0.x) + rne_shift(r_prod_x, T_FRAC);
    assign n_cy = 64'(r_cry[CRY_N-2].p0.y) + rne_shift(r_prod_y, T_FRAC);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_cry[0] <= '{vis: !(i_p0.z < NEAR_Q && i_p1.z < NEAR_Q), p0: i_p0, p1: i_p1};
            for (int k = 1; k < CRY_N; k++) begin
                r_cry[k] <= r_cry[k-1];
            end
            r_num <= NW'(NEAR_Q) - NW'(i_p0.z);
            r_den <= NW'(i_p1.z) - NW'(i_p0.z);
            r_nn  <= n_nn;
            r_dd  <= n_dd;
            // restoring divider, one quotient bit per stage
            r_rem[0] <= n_ge0 ? (r_nn - r_dd) : r_nn;
            r_q[0]   <= {{T_FRAC{1'b0}}, n_ge0};
            r_dv[0]  <= r_dd;
            for (int j = 1; j <= T_FRAC; j++) begin
                r_rem[j] <= n_rem[j];
                r_q[j]   <= {r_q[j-1][T_FRAC-1:0], n_ge[j]};
                r_dv[j]  <= r_dv[j-1];
            end
            r_s <= r_q[T_FRAC] + (T_FRAC+1)'(n_up);
            // split products of coordinate delta and fraction
            r_mlo_x <= 47'(n_dfx[17:0]) * 47'(r_s);
            r_mlo_y <= 47'(n_dfy[17:0]) * 47'(r_s);
            r_mhi_x <= 47'($signed(n_dfx[NW-1:18])) * 47'($signed({1'b0, r_s}));
            r_mhi_y <= 47'($signed(n_dfy[NW-1:18])) * 47'($signed({1'b0, r_s}));
            r_prod_x <= $signed((64'(r_mhi_x) <<< 18) + 64'(r_mlo_x));
            r_prod_y <= $signed((64'(r_mhi_y) <<< 18) + 64'(r_mlo_y));
            r_crx   <= CW'(n_cx);
            r_cry_y <= CW'(n_cy);
            // endpoints not beyond the near plane take the crossing
            r_vis <= r_cry[CRY_N-1].vis;
            if (r_cry[CRY_N-1].p0.z > NEAR_Q) begin
                r_q0 <= r_cry[CRY_N-1].p0;
            end else begin
                r_q0 <= '{x: r_crx, y: r_cry_y, z: NEAR_Q};
            end
            if (r_cry[CRY_N-1].p1.z > NEAR_Q) begin
                r_q1 <= r_cry[CRY_N-1].p1;
            end else begin
                r_q1 <= '{x: r_crx, y: r_cry_y, z: NEAR_Q};
            end
        end
    end

    assign o_vis = r_vis;
    assign o_q0  = r_q0;
    assign o_q1  = r_q1;

endmodule

>>> hdl/scp_pixel.sv
module scp_pixel (
    input  logic                       i_clk,
    input  logic                       i_en,
    input  logic signed [scp_pkg::CW-1:0] i_p,
    input  logic signed [scp_pkg::CW-1:0] i_z,
    input  logic [15:0]                i_f,
    input  logic [15:0]                i_c,
    output logic signed [15:0]         o_val
);
    import scp_pkg::*;

    localparam int MW = CW + 17;
    localparam int AW = MW + 1;
    localparam int DW = CW + 4;
    localparam int XW = AW + 3;

    logic signed [MW-1:0] r_m1, r_m2;
    logic [DW-1:0]        r_d0, r_d1;
    logic                 r_neg0;
    logic [AW-1:0]        r_an;
    logic [AW-1:0]        r_rem [0:QB];
    logic [QB-1:0]        r_q   [0:QB];
    logic [DW-1:0]        r_dv  [0:QB];
    logic                 r_ng  [0:QB];
    logic                 r_ov  [0:QB];
    logic [QB:0]          r_mag;
    logic                 r_neg_f, r_ov_f;
    logic signed [15:0]   r_val;

    logic signed [AW-1:0] n_sum;
    logic [XW-1:0]        n_sub [1:QB];
    logic                 n_ge  [1:QB];
    logic                 n_up;

    assign n_sum = AW'(r_m1) + AW'(r_m2);

    always_comb begin
        for (int j = 1; j <= QB; j++) begin
            n_sub[j] = XW'(r_dv[j-1]) << (QB - j);
            n_ge[j]  = XW'(r_rem[j-1]) >= n_sub[j];
        end
    end

    assign n_up = ({1'b0, r_rem[QB]} << 1) > (AW+1)'(r_dv[QB])
               || ((({1'b0, r_rem[QB]} << 1) == (AW+1)'(r_dv[QB])) && r_q[QB][0]);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_m1 <= MW'($signed({1'b0, i_f})) * MW'(i_p);
            r_m2 <= MW'($signed({1'b0, i_c})) * MW'(i_z);
            r_d0 <= DW'($unsigned(i_z)) << 4;
            // magnitude divide; rounding is symmetric about zero
            r_neg0 <= n_sum[AW-1];
            r_an   <= n_sum[AW-1] ? $unsigned(-n_sum) : $unsigned(n_sum);
            r_d1   <= r_d0;
            r_rem[0] <= r_an;
            r_q[0]   <= '0;
            r_dv[0]  <= r_d1;
            r_ng[0]  <= r_neg0;
            r_ov[0]  <= XW'(r_an) >= (XW'(r_d1) << QB);
            for (int j = 1; j <= QB; j++) begin
                r_rem[j] <= n_ge[j] ? AW'(XW'(r_rem[j-1]) - n_sub[j]) : r_rem[j-1];
                r_q[j]   <= {r_q[j-1][QB-2:0], n_ge[j]};
                r_dv[j]  <= r_dv[j-1];
                r_ng[j]  <= r_ng[j-1];
                r_ov[j]  <= r_ov[j-1];
            end
            r_mag   <= (QB+1)'(r_q[QB]) + (QB+1)'(n_up);
            r_neg_f <= r_ng[QB];
            r_ov_f  <= r_ov[QB];
            // saturate to the 16-bit pixel range
            if (r_neg_f) begin
                if (r_ov_f || r_mag > (QB+1)'(32768)) begin
                    r_val <= -16'sd32768;
                end else begin
                    r_val <= 16'(-$signed({1'b0, r_mag}));
                end
            end else begin
                if (r_ov_f || r_mag > (QB+1)'(32767)) begin
                    r_val <= 16'sd32767;
                end else begin
                    r_val <= 16'(r_mag);
                end
            end
        end
    end

    assign o_val = r_val;

endmodule

>>> hdl/segment_camera_project.sv
// channel | signals                              | word
// in      | i_in_valid, o_in_stall, i_in_word    | t_in_word: one segment, world units
// out     | o_out_valid, i_out_stall, o_out_word | t_out_word: visibility and pixels
// cfg     | i_cfg_we, i_cfg_index, i_cfg_data    | 32-bit register write
// One segment enters per cycle unless a result is stalled; each passes through
// rotation, then clipping (including the crossing-fraction divider), then
// the pixel divide and saturation.
// Reset clears the valid bits and loads the default camera registers.
// A stalled result freezes the whole pipeline; bubbles are not squeezed out.
module segment_camera_project (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  scp_pkg::t_in_word    i_in_word,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output scp_pkg::t_out_word   o_out_word,
    input  logic                 i_cfg_we,
    input  logic [2:0]           i_cfg_index,
    input  logic [31:0]          i_cfg_data
);
    import scp_pkg::*;

    logic signed [19:0] r_cam_x, r_cam_y, r_cam_z;
    logic [31:0]        r_heading, r_tilt, r_focal, r_principal;
    logic [PIPE_LAT-1:0] r_vld;
    logic [PIX_LAT-1:0]  r_vis_d;

    logic     n_adv;
    t_rot_cfg n_rot;
    t_cam_pt  n_p0, n_p1, n_q0, n_q1;
    logic     n_vis;
    logic signed [15:0] n_su, n_sv, n_eu, n_ev;

    assign n_adv = !(r_vld[PIPE_LAT-1] && i_out_stall);
    assign o_in_stall  = !n_adv;
    assign o_out_valid = r_vld[PIPE_LAT-1];

    assign n_rot = '{cph: r_heading[31:16], sph: r_heading[15:0],
                     ct: r_tilt[31:16], st: r_tilt[15:0]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cam_x     <= 20'sd0;
            r_cam_y     <= 20'sd8000;
            r_cam_z     <= 20'sd1600;
            r_heading   <= 32'd1065748429;
            r_tilt      <= 32'd1069742700;
            r_focal     <= 32'd547496134;
            r_principal <= 32'd313593643;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_CAM_X:     r_cam_x     <= i_cfg_data[19:0];
                CFG_CAM_Y:     r_cam_y     <= i_cfg_data[19:0];
                CFG_CAM_Z:     r_cam_z     <= i_cfg_data[19:0];
                CFG_HEADING:   r_heading   <= i_cfg_data;
                CFG_TILT:      r_tilt      <= i_cfg_data;
                CFG_FOCAL:     r_focal     <= i_cfg_data;
                CFG_PRINCIPAL: r_principal <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (n_adv) begin
            r_vld <= {r_vld[PIPE_LAT-2:0], i_in_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (n_adv) begin
            r_vis_d <= {r_vis_d[PIX_LAT-2:0], n_vis};
        end
    end

    scp_rotate u_rot0 (
        .i_clk(i_clk), .i_en(n_adv), .i_rot(n_rot),
        .i_cam_x(r_cam_x), .i_cam_y(r_cam_y), .i_cam_z(r_cam_z),
        .i_x(i_in_word.start_x), .i_y(i_in_word.start_y), .i_z(i_in_word.start_z),
        .o_pt(n_p0)
    );

    scp_rotate u_rot1 (
        .i_clk(i_clk), .i_en(n_adv), .i_rot(n_rot),
        .i_cam_x(r_cam_x), .i_cam_y(r_cam_y), .i_cam_z(r_cam_z),
        .i_x(i_in_word.end_x), .i_y(i_in_word.end_y), .i_z(i_in_word.end_z),
        .o_pt(n_p1)
    );

    scp_clip u_clip (
        .i_clk(i_clk), .i_en(n_adv), .i_p0(n_p0), .i_p1(n_p1),
        .o_vis(n_vis), .o_q0(n_q0), .o_q1(n_q1)
    );

    scp_pixel u_su (
        .i_clk(i_clk), .i_en(n_adv), .i_p(n_q0.x), .i_z(n_q0.z),
        .i_f(r_focal[31:16]), .i_c(r_principal[31:16]), .o_val(n_su)
    );

    scp_pixel u_sv (
        .i_clk(i_clk), .i_en(n_adv), .i_p(n_q0.y), .i_z(n_q0.z),
        .i_f(r_focal[15:0]), .i_c(r_principal[15:0]), .o_val(n_sv)
    );

    scp_pixel u_eu (
        .i_clk(i_clk), .i_en(n_adv), .i_p(n_q1.x), .i_z(n_q1.z),
        .i_f(r_focal[31:16]), .i_c(r_principal[31:16]), .o_val(n_eu)
    );

    scp_pixel u_ev (
        .i_clk(i_clk), .i_en(n_adv), .i_p(n_q1.y), .i_z(n_q1.z),
        .i_f(r_focal[15:0]), .i_c(r_principal[15:0]), .o_val(n_ev)
    );

    // drop the pixels of a segment wholly in front of the near plane
    assign o_out_word.visible = r_vis_d[PIX_LAT-1];
    assign o_out_word.start_u = r_vis_d[PIX_LAT-1] ? n_su : 16'sd0;
    assign o_out_word.start_v = r_vis_d[PIX_LAT-1] ? n_sv : 16'sd0;
    assign o_out_word.end_u   = r_vis_d[PIX_LAT-1] ? n_eu : 16'sd0;
    assign o_out_word.end_v   = r_vis_d[PIX_LAT-1] ? n_ev : 16'sd0;

endmodule
